// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that carry checks (here facing_cone_test_unit).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define FCT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define FCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/fct_pkg.sv -----
// Shared constants and types for the facing cone test pipeline.
package fct_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int HEADING_W = 16;
    localparam int THR_W     = 16;
    localparam int THR2_W    = 32;

    localparam logic [THR_W-1:0]  THR_RESET  = 16'd23167;
    localparam logic [THR2_W-1:0] THR2_RESET = 32'(THR_RESET * THR_RESET);

    // Quarter-sine polynomial, Q15 fraction
    localparam int Z_W     = 16;
    localparam int FRAC    = 15;
    localparam int QUARTER = 16384;
    localparam int SIN_ONE = 32768;
    localparam int SIN_A   = 51472;
    localparam int SIN_B   = 21024;
    localparam int SIN_C   = 2320;

    // Heading quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic [Z_W-1:0] zval_t;

endpackage

// ----- rtl/fct_sine.sv -----
// Four-stage quarter-sine polynomial evaluator, Q15 in and out.
module fct_sine (
    input  logic          clk,
    input  logic [3:0]    en,
    input  fct_pkg::zval_t z,
    output fct_pkg::zval_t s
);

    localparam int MUL_W  = 32;
    localparam int ZC_W   = 12;
    localparam int DIFF_W = MUL_W + 1;

    // Stage a: z and z squared
    fct_pkg::zval_t za_reg, z2a_reg;
    logic [MUL_W-1:0] zsq;
    fct_pkg::zval_t z2a_next;

    // Stage b: z cubed, correction term and linear term
    fct_pkg::zval_t z3b_reg;
    logic [ZC_W-1:0] zcb_reg;
    logic [MUL_W-1:0] azb_reg;
    logic [MUL_W-1:0] m3, mc;
    fct_pkg::zval_t z3b_next;
    logic [ZC_W-1:0] zcb_next;
    logic [MUL_W-1:0] azb_next;

    // Stage c: cubic term
    logic [MUL_W-1:0] azc_reg, prodc_reg;
    fct_pkg::zval_t inner;
    logic [MUL_W-1:0] prodc_next;

    // Stage d: clamped result
    fct_pkg::zval_t sd_reg, sd_next;
    logic signed [DIFF_W-1:0] diff, sh;

    assign zsq      = MUL_W'(z) * MUL_W'(z);
    assign z2a_next = zsq[fct_pkg::FRAC +: fct_pkg::Z_W];

    assign m3       = MUL_W'(z2a_reg) * MUL_W'(za_reg);
    assign mc       = MUL_W'(z2a_reg) * MUL_W'(fct_pkg::SIN_C);
    assign z3b_next = m3[fct_pkg::FRAC +: fct_pkg::Z_W];
    assign zcb_next = mc[fct_pkg::FRAC +: ZC_W];
    assign azb_next = MUL_W'(fct_pkg::SIN_A) * MUL_W'(za_reg);

    assign inner      = fct_pkg::Z_W'(fct_pkg::SIN_B) - fct_pkg::Z_W'(zcb_reg);
    assign prodc_next = MUL_W'(z3b_reg) * MUL_W'(inner);

    always_comb
    begin
        diff = $signed({1'b0, azc_reg}) - $signed({1'b0, prodc_reg});
        sh   = diff >>> fct_pkg::FRAC;
        if (diff[DIFF_W-1])
        begin
            sd_next = '0;
        end
        else if (sh > fct_pkg::SIN_ONE)
        begin
            sd_next = fct_pkg::Z_W'(fct_pkg::SIN_ONE);
        end
        else
        begin
            sd_next = sh[fct_pkg::Z_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            za_reg  <= z;
            z2a_reg <= z2a_next;
        end
        if (en[1])
        begin
            z3b_reg <= z3b_next;
            zcb_reg <= zcb_next;
            azb_reg <= azb_next;
        end
        if (en[2])
        begin
            azc_reg   <= azb_reg;
            prodc_reg <= prodc_next;
        end
        if (en[3])
        begin
            sd_reg <= sd_next;
        end
    end

    assign s = sd_reg;

endmodule

// ----- rtl/facing_cone_test_unit.sv -----
// Facing cone test: pipelined dot-product check of a target against a heading cone.
// A transfer in crosses the stage registers and the output register to reach result_valid.
// One item per cycle while result_stall is low; a full stage holds while its successor holds.
// Reset clears every stage valid bit and result_valid, and loads the threshold with 23167.
// The threshold port takes a write in every cycle (cfg_ready is tied high).
`include "assert_macros.svh"

module facing_cone_test_unit #(
    parameter int COORD_BITS = fct_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = fct_pkg::ANGLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // threshold write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fct_pkg::THR_W-1:0]           cfg_data,

    // item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                target_valid,
    input  logic signed [COORD_BITS-1:0]        self_x,
    input  logic signed [COORD_BITS-1:0]        self_y,
    input  logic signed [COORD_BITS-1:0]        target_x,
    input  logic signed [COORD_BITS-1:0]        target_y,
    input  logic [fct_pkg::HEADING_W-1:0]       heading,

    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                facing
);

    // Datapath widths, all following from the coordinate width.
    localparam int DW   = COORD_BITS + 1;          // signed offset
    localparam int MW   = COORD_BITS;              // offset magnitude
    localparam int SQW  = 2 * COORD_BITS;          // one squared component
    localparam int LW   = 2 * COORD_BITS + 1;      // squared length
    localparam int LLO  = COORD_BITS + 1;          // low slice of length for threshold product
    localparam int LHI  = LW - LLO;
    localparam int RLW  = LLO + fct_pkg::THR2_W;
    localparam int RHW  = LHI + fct_pkg::THR2_W;
    localparam int RW   = LW + fct_pkg::THR2_W;    // right-hand side of the compare
    localparam int PW   = 17 + DW;                 // one signed dot term
    localparam int DTW  = PW + 1;                  // signed dot product
    localparam int DMW  = COORD_BITS + 16;         // magnitude of a non-negative dot
    localparam int DLO  = (DMW + 1) / 2;
    localparam int DHI  = DMW - DLO;
    localparam int QW   = 2 * DMW;                 // dot squared
    localparam int AZ   = fct_pkg::HEADING_W - ANGLE_BITS;
    localparam int NST  = 9;                       // stages ahead of the output register

    // ------------------------------------------------------------------
    // Threshold register. Square it on the write so the pipeline reads a
    // ready-made threshold squared; the zero check reads the threshold itself.
    // ------------------------------------------------------------------
    logic [fct_pkg::THR_W-1:0]  thr_reg;
    logic [fct_pkg::THR2_W-1:0] thr2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= fct_pkg::THR_RESET;
            thr2_reg <= fct_pkg::THR2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg  <= cfg_data;
            thr2_reg <= fct_pkg::THR2_W'(cfg_data) * fct_pkg::THR2_W'(cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage advances when it is empty or when the
    // stage after it advances, so bubbles close up behind a stalled
    // result and a transfer in is taken while the output still waits.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg, vld_next;
    logic [NST-1:0] stage_en;
    logic           out_vld_reg, out_vld_next;
    logic           en_out;

    always_comb
    begin
        en_out             = !out_vld_reg || !result_stall;
        stage_en[NST-1]    = !vld_reg[NST-1] || en_out;
        for (int k = NST - 2; k >= 0; k--)
        begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end

        vld_next[0] = stage_en[0] ? item_valid : vld_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            vld_next[k] = stage_en[k] ? vld_reg[k-1] : vld_reg[k];
        end
        out_vld_next = en_out ? vld_reg[NST-1] : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign item_stall   = !stage_en[0];
    assign result_valid = out_vld_reg;

    // ------------------------------------------------------------------
    // Stage 1: form the offset and keep the heading at its resolution.
    // ------------------------------------------------------------------
    logic                           s1_tv_reg;
    logic signed [DW-1:0]           s1_dx_reg, s1_dy_reg;
    logic [ANGLE_BITS-1:0]          s1_ang_reg;
    logic signed [DW-1:0]           s1_dx_next, s1_dy_next;

    assign s1_dx_next = DW'(target_x) - DW'(self_x);
    assign s1_dy_next = DW'(target_y) - DW'(self_y);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_tv_reg  <= target_valid;
            s1_dx_reg  <= s1_dx_next;
            s1_dy_reg  <= s1_dy_next;
            s1_ang_reg <= heading[fct_pkg::HEADING_W-1 -: ANGLE_BITS];
        end
    end

    // Split the heading into quadrant and in-quadrant angle, and build
    // the doubled arguments for the sine and the complementary sine.
    logic [fct_pkg::HEADING_W-1:0]  ang_full;
    logic [1:0]                     s1_quad;
    logic [13:0]                    ang_r;
    fct_pkg::zval_t                 t_c, z_r, z_c;

    assign ang_full = fct_pkg::HEADING_W'(s1_ang_reg) << AZ;
    assign s1_quad  = ang_full[15:14];
    assign ang_r    = ang_full[13:0];
    assign t_c      = fct_pkg::Z_W'(fct_pkg::QUARTER) - fct_pkg::Z_W'(ang_r);
    assign z_r      = fct_pkg::Z_W'(ang_r) << 1;
    assign z_c      = t_c << 1;

    // Stages 2 to 5 of the sine path live in the two evaluators.
    fct_pkg::zval_t s5_sr, s5_sc;

    fct_sine u_sine_r (
        .clk (clk),
        .en  (stage_en[4:1]),
        .z   (z_r),
        .s   (s5_sr)
    );

    fct_sine u_sine_c (
        .clk (clk),
        .en  (stage_en[4:1]),
        .z   (z_c),
        .s   (s5_sc)
    );

    // ------------------------------------------------------------------
    // Stage 2: offset magnitudes and the zero-offset flag.
    // ------------------------------------------------------------------
    logic                   s2_tv_reg, s2_zero_reg;
    logic [1:0]             s2_quad_reg;
    logic signed [DW-1:0]   s2_dx_reg, s2_dy_reg;
    logic [MW-1:0]          s2_dxa_reg, s2_dya_reg;
    logic [MW-1:0]          s2_dxa_next, s2_dya_next;
    logic                   s2_zero_next;

    assign s2_dxa_next  = MW'(s1_dx_reg[DW-1] ? -s1_dx_reg : s1_dx_reg);
    assign s2_dya_next  = MW'(s1_dy_reg[DW-1] ? -s1_dy_reg : s1_dy_reg);
    assign s2_zero_next = (s1_dx_reg == '0) && (s1_dy_reg == '0);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_tv_reg   <= s1_tv_reg;
            s2_zero_reg <= s2_zero_next;
            s2_quad_reg <= s1_quad;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;
            s2_dxa_reg  <= s2_dxa_next;
            s2_dya_reg  <= s2_dya_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: square each offset component.
    // ------------------------------------------------------------------
    logic                   s3_tv_reg, s3_zero_reg;
    logic [1:0]             s3_quad_reg;
    logic signed [DW-1:0]   s3_dx_reg, s3_dy_reg;
    logic [SQW-1:0]         s3_sqx_reg, s3_sqy_reg;
    logic [SQW-1:0]         s3_sqx_next, s3_sqy_next;

    assign s3_sqx_next = SQW'(s2_dxa_reg) * SQW'(s2_dxa_reg);
    assign s3_sqy_next = SQW'(s2_dya_reg) * SQW'(s2_dya_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_tv_reg   <= s2_tv_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_quad_reg <= s2_quad_reg;
            s3_dx_reg   <= s2_dx_reg;
            s3_dy_reg   <= s2_dy_reg;
            s3_sqx_reg  <= s3_sqx_next;
            s3_sqy_reg  <= s3_sqy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squared length.
    // ------------------------------------------------------------------
    logic                   s4_tv_reg, s4_zero_reg;
    logic [1:0]             s4_quad_reg;
    logic signed [DW-1:0]   s4_dx_reg, s4_dy_reg;
    logic [LW-1:0]          s4_len2_reg, s4_len2_next;

    assign s4_len2_next = LW'(s3_sqx_reg) + LW'(s3_sqy_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s4_tv_reg   <= s3_tv_reg;
            s4_zero_reg <= s3_zero_reg;
            s4_quad_reg <= s3_quad_reg;
            s4_dx_reg   <= s3_dx_reg;
            s4_dy_reg   <= s3_dy_reg;
            s4_len2_reg <= s4_len2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: length squared times threshold squared, in two slices.
    // ------------------------------------------------------------------
    logic                   s5_tv_reg, s5_zero_reg;
    logic [1:0]             s5_quad_reg;
    logic signed [DW-1:0]   s5_dx_reg, s5_dy_reg;
    logic [RLW-1:0]         s5_rlo_reg, s5_rlo_next;
    logic [RHW-1:0]         s5_rhi_reg, s5_rhi_next;

    assign s5_rlo_next = RLW'(s4_len2_reg[LLO-1:0]) * RLW'(thr2_reg);
    assign s5_rhi_next = RHW'(s4_len2_reg[LW-1:LLO]) * RHW'(thr2_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s5_tv_reg   <= s4_tv_reg;
            s5_zero_reg <= s4_zero_reg;
            s5_quad_reg <= s4_quad_reg;
            s5_dx_reg   <= s4_dx_reg;
            s5_dy_reg   <= s4_dy_reg;
            s5_rlo_reg  <= s5_rlo_next;
            s5_rhi_reg  <= s5_rhi_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: pick cosine and sine magnitudes by quadrant and multiply
    // with the offset; carry the signs to the sum. Join the threshold
    // slices into the right-hand side.
    // ------------------------------------------------------------------
    logic                   swap, cneg, sneg;
    fct_pkg::zval_t         c_mag, s_mag;

    always_comb
    begin
        unique case (s5_quad_reg)
            fct_pkg::QUAD_0:
            begin
                swap = 1'b0; cneg = 1'b0; sneg = 1'b0;
            end
            fct_pkg::QUAD_1:
            begin
                swap = 1'b1; cneg = 1'b1; sneg = 1'b0;
            end
            fct_pkg::QUAD_2:
            begin
                swap = 1'b0; cneg = 1'b1; sneg = 1'b1;
            end
            default:
            begin
                swap = 1'b1; cneg = 1'b0; sneg = 1'b1;
            end
        endcase
        c_mag = swap ? s5_sr : s5_sc;
        s_mag = swap ? s5_sc : s5_sr;
    end

    logic                   s6_tv_reg, s6_zero_reg, s6_cneg_reg, s6_sneg_reg;
    logic signed [PW-1:0]   s6_pc_reg, s6_ps_reg, s6_pc_next, s6_ps_next;
    logic [RW-1:0]          s6_rhs_reg, s6_rhs_next;

    assign s6_pc_next  = PW'($signed({1'b0, c_mag})) * PW'(s5_dx_reg);
    assign s6_ps_next  = PW'($signed({1'b0, s_mag})) * PW'(s5_dy_reg);
    assign s6_rhs_next = RW'(s5_rlo_reg) + (RW'(s5_rhi_reg) << LLO);

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            s6_tv_reg   <= s5_tv_reg;
            s6_zero_reg <= s5_zero_reg;
            s6_cneg_reg <= cneg;
            s6_sneg_reg <= sneg;
            s6_pc_reg   <= s6_pc_next;
            s6_ps_reg   <= s6_ps_next;
            s6_rhs_reg  <= s6_rhs_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: signed dot product.
    // ------------------------------------------------------------------
    logic                   s7_tv_reg, s7_zero_reg;
    logic [RW-1:0]          s7_rhs_reg;
    logic signed [DTW-1:0]  s7_dot_reg, s7_dot_next;

    assign s7_dot_next = (s6_cneg_reg ? -DTW'(s6_pc_reg) : DTW'(s6_pc_reg))
                       + (s6_sneg_reg ? -DTW'(s6_ps_reg) : DTW'(s6_ps_reg));

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            s7_tv_reg   <= s6_tv_reg;
            s7_zero_reg <= s6_zero_reg;
            s7_rhs_reg  <= s6_rhs_reg;
            s7_dot_reg  <= s7_dot_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: partial products of dot squared. A negative dot fails
    // anyway, so its magnitude bits are don't-care.
    // ------------------------------------------------------------------
    logic [DMW-1:0]         dot_mag;
    logic [DLO-1:0]         dot_lo;
    logic [DHI-1:0]         dot_hi;

    assign dot_mag = s7_dot_reg[DMW-1:0];
    assign dot_lo  = dot_mag[DLO-1:0];
    assign dot_hi  = dot_mag[DMW-1:DLO];

    logic                   s8_tv_reg, s8_zero_reg, s8_dneg_reg;
    logic [RW-1:0]          s8_rhs_reg;
    logic [2*DHI-1:0]       s8_hh_reg, s8_hh_next;
    logic [DHI+DLO-1:0]     s8_hl_reg, s8_hl_next;
    logic [2*DLO-1:0]       s8_ll_reg, s8_ll_next;

    assign s8_hh_next = (2*DHI)'(dot_hi) * (2*DHI)'(dot_hi);
    assign s8_hl_next = (DHI+DLO)'(dot_hi) * (DHI+DLO)'(dot_lo);
    assign s8_ll_next = (2*DLO)'(dot_lo) * (2*DLO)'(dot_lo);

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            s8_tv_reg   <= s7_tv_reg;
            s8_zero_reg <= s7_zero_reg;
            s8_dneg_reg <= s7_dot_reg[DTW-1];
            s8_rhs_reg  <= s7_rhs_reg;
            s8_hh_reg   <= s8_hh_next;
            s8_hl_reg   <= s8_hl_next;
            s8_ll_reg   <= s8_ll_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: assemble dot squared.
    // ------------------------------------------------------------------
    logic                   s9_tv_reg, s9_zero_reg, s9_dneg_reg;
    logic [RW-1:0]          s9_rhs_reg;
    logic [QW-1:0]          s9_lhs_reg, s9_lhs_next;

    assign s9_lhs_next = (QW'(s8_hh_reg) << (2 * DLO))
                       + (QW'(s8_hl_reg) << (DLO + 1))
                       + QW'(s8_ll_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            s9_tv_reg   <= s8_tv_reg;
            s9_zero_reg <= s8_zero_reg;
            s9_dneg_reg <= s8_dneg_reg;
            s9_rhs_reg  <= s8_rhs_reg;
            s9_lhs_reg  <= s9_lhs_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: final compare. An absent target never faces; a
    // target on the observer faces only under a zero threshold.
    // ------------------------------------------------------------------
    logic facing_reg, facing_next;

    assign facing_next = s9_tv_reg
                      && (s9_zero_reg ? (thr_reg == '0)
                                      : (!s9_dneg_reg && (RW'(s9_lhs_reg) >= s9_rhs_reg)));

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            facing_reg <= facing_next;
        end
    end

    assign facing = facing_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `FCT_ASSERT_NOW(a_thr_square, 1'b1, thr2_reg == fct_pkg::THR2_W'(thr_reg * thr_reg))
    `FCT_ASSERT_NEXT(a_mid_hold, vld_reg[4] && !stage_en[4], vld_reg[4])
    `FCT_ASSERT_NOW(a_dot_fits, vld_reg[6] && !s7_dot_reg[DTW-1], s7_dot_reg[DTW-2:DMW] == '0)
    `FCT_ASSERT_NEXT(a_absent_target, vld_reg[8] && en_out && !s9_tv_reg, out_vld_reg && !facing_reg)

endmodule

// ----- tb/sv/tb_facing_cone_test_unit.sv -----
// Self-checking testbench for the facing cone test unit: directed and random geometric queries.
`timescale 1ns / 1ps

module tb_facing_cone_test_unit;

    // Widths follow the block's defaults
    localparam int COORD_W = fct_pkg::COORD_BITS_DEF;
    localparam int ANGLE_W = fct_pkg::ANGLE_BITS_DEF;

    // Quarter-sine polynomial terms (Q15) and the angle of a quarter turn
    localparam longint POLY_A       = 51472;
    localparam longint POLY_B       = 21024;
    localparam longint POLY_C       = 2320;
    localparam longint QUARTER_TURN = 16384;
    localparam longint Q15_ONE      = 32768;

    // Coordinate extremes used by the directed part and by the random queries
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));

    // Cycles to let pass after the last result before touching the threshold
    localparam int SETTLE_CYCLES = 12;

    typedef logic signed [COORD_W-1:0]          coord_t;
    typedef logic [fct_pkg::HEADING_W-1:0]      heading_t;
    typedef logic [fct_pkg::THR_W-1:0]          thr_t;

    // One geometric query as it crosses the item channel
    typedef struct {
        logic     target_valid;
        coord_t   self_x;
        coord_t   self_y;
        coord_t   target_x;
        coord_t   target_y;
        heading_t heading;
    } query_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;

    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    thr_t     cfg_data = '0;

    logic     item_valid = 1'b0;
    logic     item_stall;
    logic     target_valid = 1'b0;
    coord_t   self_x = '0;
    coord_t   self_y = '0;
    coord_t   target_x = '0;
    coord_t   target_y = '0;
    heading_t heading = '0;

    logic     result_valid;
    logic     result_stall = 1'b0;
    logic     facing;

    // Queries waiting to be driven, and verdicts waiting for their result transfer
    query_t   query_backlog[$];
    bit       facing_expected[$];

    // Query currently on the item channel, and the threshold the block now holds
    query_t   query_on_bus;
    thr_t     threshold_now = fct_pkg::THR_RESET;

    // Chance in a hundred that either side idles in a given cycle
    int       idle_pct = 17;
    int       fault_count = 0;
    bit       verdict;

    facing_cone_test_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .target_valid (target_valid),
        .self_x       (self_x),
        .self_y       (self_y),
        .target_x     (target_x),
        .target_y     (target_y),
        .heading      (heading),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .facing       (facing)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Q15 sine of t/16384 quarter turns, first quadrant only, clamped to 0..1.0
    function automatic longint q15_sine(input longint t);
        longint z, z2, z3, inner, s;
        z     = t * 2;
        z2    = (z * z) >>> 15;
        z3    = (z2 * z) >>> 15;
        inner = POLY_B - ((z2 * POLY_C) >>> 15);
        s     = (POLY_A * z - z3 * inner) >>> 15;
        if (s < 0)
            s = 0;
        if (s > Q15_ONE)
            s = Q15_ONE;
        return s;
    endfunction

    // Decide whether the target lies inside the cone, squared form, exact in 128 bits
    function automatic bit cone_facing(input query_t q, input thr_t thr);
        heading_t     ang;
        logic [1:0]   quad;
        longint       frac, sin_r, sin_c, cx, sy, dx, dy, dot;
        logic [127:0] dot_w, len_w, thr_w;
        ang   = (q.heading >> (16 - ANGLE_W)) << (16 - ANGLE_W);
        quad  = ang[15:14];
        frac  = longint'(ang[13:0]);
        sin_r = q15_sine(frac);
        sin_c = q15_sine(QUARTER_TURN - frac);
        // Fold the quadrant back onto the first-quadrant sine
        case (quad)
            fct_pkg::QUAD_0:
            begin
                cx = sin_c;
                sy = sin_r;
            end
            fct_pkg::QUAD_1:
            begin
                cx = -sin_r;
                sy = sin_c;
            end
            fct_pkg::QUAD_2:
            begin
                cx = -sin_c;
                sy = -sin_r;
            end
            default:
            begin
                cx = sin_r;
                sy = -sin_c;
            end
        endcase
        dx = longint'(q.target_x) - longint'(q.self_x);
        dy = longint'(q.target_y) - longint'(q.self_y);
        if (!q.target_valid)
            return 1'b0;
        // Target on top of the observer: only a zero threshold admits it
        if (dx == 0 && dy == 0)
            return (thr == '0);
        dot = cx * dx + sy * dy;
        if (dot < 0)
            return 1'b0;
        dot_w = 128'(dot);
        len_w = 128'(dx * dx + dy * dy);
        thr_w = 128'(thr) * 128'(thr);
        return (dot_w * dot_w >= len_w * thr_w);
    endfunction

    // Driver: offer queued queries on the item channel, holding each until its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            target_valid <= 1'b0;
            self_x       <= '0;
            self_y       <= '0;
            target_x     <= '0;
            target_y     <= '0;
            heading      <= '0;
        end
        else
        begin
            // Predict at the transfer, with the threshold in force now
            if (item_valid && !item_stall)
                facing_expected.push_back(cone_facing(query_on_bus, threshold_now));
            // A stalled query holds its payload and its valid untouched
            if (!(item_valid && item_stall))
            begin
                if (query_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    query_on_bus = query_backlog.pop_front();
                    item_valid   <= 1'b1;
                    target_valid <= query_on_bus.target_valid;
                    self_x       <= query_on_bus.self_x;
                    self_y       <= query_on_bus.self_y;
                    target_x     <= query_on_bus.target_x;
                    target_y     <= query_on_bus.target_y;
                    heading      <= query_on_bus.heading;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every result transfer against the oldest verdict, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (facing_expected.size() == 0)
                begin
                    $display("%0t: result with nothing expected, facing %0b", $time, facing);
                    fault_count++;
                end
                else
                begin
                    verdict = facing_expected.pop_front();
                    if (facing !== verdict)
                    begin
                        $display("%0t: facing mismatch, expected %0b, actual %0b",
                                 $time, verdict, facing);
                        fault_count++;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    task automatic enqueue_query(input bit tv, input longint sx, input longint sy,
                                 input longint tx, input longint ty, input longint hd);
        query_t q;
        q.target_valid = tv;
        q.self_x       = coord_t'(sx);
        q.self_y       = coord_t'(sy);
        q.target_x     = coord_t'(tx);
        q.target_y     = coord_t'(ty);
        q.heading      = heading_t'(hd);
        query_backlog.push_back(q);
    endtask

    // Random query: mostly an observer and a target at a random offset of random scale
    function automatic query_t random_query();
        query_t q;
        longint span, ox, oy;
        q.target_valid = ($urandom_range(9) != 0);
        q.self_x       = coord_t'($urandom);
        q.self_y       = coord_t'($urandom);
        q.heading      = heading_t'($urandom);
        // Push the observer to the edges of the coordinate range now and then
        if ($urandom_range(19) == 0)
            q.self_x = coord_t'($urandom_range(1) ? COORD_MAX : COORD_MIN);
        if ($urandom_range(19) == 0)
            q.self_y = coord_t'($urandom_range(1) ? COORD_MAX : COORD_MIN);
        case ($urandom_range(9))
            0:
            begin
                span = 0;
                ox   = longint'(coord_t'($urandom)) - longint'(q.self_x);
                oy   = longint'(coord_t'($urandom)) - longint'(q.self_y);
            end
            1:
            begin
                // Tiny offsets, zero among them
                span = 2;
                ox   = longint'($urandom_range(32'(2 * span))) - span;
                oy   = longint'($urandom_range(32'(2 * span))) - span;
            end
            2:
            begin
                // Offsets along an axis, heading on a quadrant boundary or next to it
                span = 64'sd1 << $urandom_range(22);
                ox   = $urandom_range(1) ? longint'($urandom_range(32'(2 * span))) - span : 0;
                oy   = (ox == 0) ? longint'($urandom_range(32'(2 * span))) - span : 0;
                q.heading = heading_t'(($urandom_range(3) << 14) + $urandom_range(2) - 1);
            end
            default:
            begin
                span = 64'sd1 << $urandom_range(23, 1);
                ox   = longint'($urandom_range(32'(2 * span))) - span;
                oy   = longint'($urandom_range(32'(2 * span))) - span;
            end
        endcase
        q.target_x = coord_t'(longint'(q.self_x) + ox);
        q.target_y = coord_t'(longint'(q.self_y) + oy);
        return q;
    endfunction

    task automatic fill_random(input int count);
        for (int i = 0; i < count; i++)
            query_backlog.push_back(random_query());
    endtask

    // Hold until every query has gone out and every verdict has been met, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        while (query_backlog.size() != 0 || item_valid || facing_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the threshold through its own channel; the model copy changes at the transfer
    task automatic write_threshold(input thr_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        threshold_now = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        // Release reset away from the rising edge
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset threshold (about 0.707): absent target, zero offset, coordinate extremes,
        // each quadrant boundary and the headings either side of a full turn
        enqueue_query(1'b0, 0, 0, 1000, 0, 0);
        enqueue_query(1'b1, 0, 0, 1000, 0, 0);
        enqueue_query(1'b1, 5, 5, 5, 5, 0);
        enqueue_query(1'b1, COORD_MIN, 0, COORD_MAX, 0, 0);
        enqueue_query(1'b1, COORD_MAX, 0, COORD_MIN, 0, 32768);
        enqueue_query(1'b1, 0, COORD_MIN, 0, COORD_MAX, 16384);
        enqueue_query(1'b1, 0, COORD_MAX, 0, COORD_MIN, 49152);
        enqueue_query(1'b1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 8192);
        enqueue_query(1'b1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0);
        enqueue_query(1'b1, 0, 0, 1000, 0, 65535);
        enqueue_query(1'b1, 0, 0, 1000, 0, 32768);
        enqueue_query(1'b1, -1, -1, -1, -1, 65535);
        enqueue_query(1'b1, 0, 0, 0, 1000, 1);
        enqueue_query(1'b1, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 40960);
        fill_random(300);
        settle();

        // Zero threshold: a target at right angles and one on top of the observer both face
        write_threshold('0);
        enqueue_query(1'b1, 7, 7, 7, 7, 0);
        enqueue_query(1'b1, 0, 0, 0, 1000, 0);
        enqueue_query(1'b1, 0, 0, -1000, 0, 0);
        enqueue_query(1'b0, 7, 7, 7, 7, 0);
        fill_random(300);
        settle();

        // Threshold of exactly one, with a stretch where neither side idles
        idle_pct = 0;
        write_threshold(thr_t'(Q15_ONE));
        enqueue_query(1'b1, 0, 0, 1000, 0, 0);
        enqueue_query(1'b1, 0, 0, 1000, 1, 0);
        enqueue_query(1'b1, 0, 0, 0, 5, 16384);
        fill_random(300);
        settle();
        idle_pct = 17;

        // Threshold above one: almost nothing faces any more
        write_threshold('1);
        enqueue_query(1'b1, 0, 0, 1000, 0, 0);
        enqueue_query(1'b1, 3, 3, 3, 3, 0);
        fill_random(50);
        settle();

        write_threshold(thr_t'($urandom_range(32767, 1)));
        fill_random(300);
        settle();

        write_threshold(fct_pkg::THR_RESET);
        fill_random(300);
        settle();

        if (fault_count == 0 && facing_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
